>>> hdl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/shc_pkg.sv
package shc_pkg;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned COIL_W   = 4;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned OFFSET_W = 10;

    localparam int unsigned CAL_RUNS_DEFAULT = 4;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(150);

    localparam logic [MODE_W-1:0] MODE_IDLE = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_FWD  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_BACK = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CAL  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_HOME = MODE_W'(4);

    localparam logic [COIL_W-1:0] COIL_TABLE [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              moved;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  rev_steps_out;
        logic              busy_res;
        logic              done_res;
    } shc_result_t;

endpackage

>>> hdl/shc_if.sv
interface shc_cfg_if;
    import shc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] offset_steps;

    modport source (output valid, output offset_steps, input ready);
    modport sink (input valid, input offset_steps, output ready);
endinterface

interface shc_step_if;
    import shc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic              opto_edge;

    modport source (output valid, output mode, output opto_edge, input ready);
    modport sink (input valid, input mode, input opto_edge, output ready);
endinterface

interface shc_result_if;
    import shc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COIL_W-1:0] coils;
    logic              moved;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  rev_steps_out;
    logic              busy_res;
    logic              done_res;

    modport source (
        output valid, output coils, output moved, output position,
        output rev_steps_out, output busy_res, output done_res, input ready
    );
    modport sink (
        input valid, input coils, input moved, input position,
        input rev_steps_out, input busy_res, input done_res, output ready
    );
endinterface

>>> hdl/shc_recip_div.sv
module shc_recip_div #(
    parameter int unsigned CAL_RUNS = shc_pkg::CAL_RUNS_DEFAULT
) (
    input  logic [shc_pkg::TOTAL_W-1:0] total,
    output logic [shc_pkg::POS_W-1:0]   quotient
);
    import shc_pkg::*;

    // Rounded-up reciprocal gives the exact floor quotient for every
    // numerator of TOTAL_W bits.
    localparam int unsigned SHIFT  = TOTAL_W + $clog2(CAL_RUNS);
    localparam int unsigned MULT_W = SHIFT + 1;
    localparam logic [MULT_W-1:0] RECIP =
        MULT_W'(((64'd1 << SHIFT) + 64'(CAL_RUNS) - 64'd1) / 64'(CAL_RUNS));
    localparam int unsigned PROD_W = TOTAL_W + MULT_W;

    logic [PROD_W-1:0] product;

    assign product  = {{MULT_W{1'b0}}, total} * {{TOTAL_W{1'b0}}, RECIP};
    assign quotient = product[SHIFT +: POS_W];
endmodule

>>> hdl/shc_seq.sv
module shc_seq #(
    parameter int unsigned CAL_RUNS = shc_pkg::CAL_RUNS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [shc_pkg::MODE_W-1:0]   mode,
    input  logic                         opto_edge,
    input  logic [shc_pkg::OFFSET_W-1:0] offset_steps,
    output shc_pkg::shc_result_t         res
);
    import shc_pkg::*;

    localparam int unsigned RUNS_W = $clog2(CAL_RUNS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL_SEEK,
        ST_CAL_COUNT,
        ST_CAL_OFFSET,
        ST_HOME_SEEK,
        ST_HOME_OFFSET
    } stage_t;

    stage_t              stage_reg, stage_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    rev_reg, rev_next;
    logic [RUNS_W-1:0]   runs_reg, runs_next;
    logic [POS_W-1:0]    run_cnt_reg, run_cnt_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    shc_result_t         res_reg, res_next;

    logic              step_fwd;
    logic              step_back;
    logic              finish;
    logic              load_rev;
    logic [RUNS_W-1:0] runs_inc;
    logic [POS_W:0]    pos_inc;
    logic [POS_W-1:0]  quotient;

    shc_recip_div #(
        .CAL_RUNS (CAL_RUNS)
    ) u_div (
        .total    (total_reg),
        .quotient (quotient)
    );

    assign runs_inc = runs_reg + 1'b1;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;

    always_comb
    begin
        stage_next   = stage_reg;
        runs_next    = runs_reg;
        run_cnt_next = run_cnt_reg;
        total_next   = total_reg;
        off_next     = off_reg;
        step_fwd     = 1'b0;
        step_back    = 1'b0;
        finish       = 1'b0;
        load_rev     = 1'b0;

        unique case (stage_reg)
            ST_IDLE:
            begin
                unique case (mode)
                    MODE_FWD:
                    begin
                        step_fwd = 1'b1;
                    end
                    MODE_BACK:
                    begin
                        step_back = 1'b1;
                    end
                    MODE_CAL:
                    begin
                        stage_next   = ST_CAL_SEEK;
                        runs_next    = '0;
                        run_cnt_next = '0;
                        total_next   = '0;
                        off_next     = '0;
                        step_fwd     = 1'b1;
                    end
                    MODE_HOME:
                    begin
                        stage_next = ST_HOME_SEEK;
                        off_next   = '0;
                        step_back  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CAL_SEEK:
            begin
                if (mode == MODE_CAL)
                begin
                    if (opto_edge)
                    begin
                        stage_next   = ST_CAL_COUNT;
                        runs_next    = '0;
                        run_cnt_next = '0;
                    end
                    else
                    begin
                        step_fwd = 1'b1;
                    end
                end
            end
            ST_CAL_COUNT:
            begin
                if (mode == MODE_CAL)
                begin
                    if (opto_edge)
                    begin
                        total_next   = total_reg + TOTAL_W'(run_cnt_reg);
                        runs_next    = runs_inc;
                        run_cnt_next = '0;
                        if (runs_inc >= RUNS_W'(CAL_RUNS))
                        begin
                            stage_next = ST_CAL_OFFSET;
                            off_next   = offset_steps;
                        end
                    end
                    else
                    begin
                        step_fwd = 1'b1;
                        if (run_cnt_reg != '1)
                        begin
                            run_cnt_next = run_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_CAL_OFFSET:
            begin
                if (mode == MODE_CAL)
                begin
                    if (off_reg != '0)
                    begin
                        step_fwd = 1'b1;
                        off_next = off_reg - 1'b1;
                    end
                    if (off_reg <= OFFSET_W'(1))
                    begin
                        finish     = 1'b1;
                        load_rev   = 1'b1;
                        stage_next = ST_IDLE;
                    end
                end
            end
            ST_HOME_SEEK:
            begin
                if (mode == MODE_HOME)
                begin
                    if (opto_edge)
                    begin
                        stage_next = ST_HOME_OFFSET;
                        off_next   = offset_steps;
                    end
                    else
                    begin
                        step_back = 1'b1;
                    end
                end
            end
            ST_HOME_OFFSET:
            begin
                if (mode == MODE_HOME)
                begin
                    if (off_reg != '0)
                    begin
                        step_back = 1'b1;
                        off_next  = off_reg - 1'b1;
                    end
                    if (off_reg <= OFFSET_W'(1))
                    begin
                        finish     = 1'b1;
                        stage_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                stage_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        if (step_fwd)
        begin
            phase_next = phase_reg + 1'b1;
            if (rev_reg == '0 || pos_inc == {1'b0, rev_reg})
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
        end
        else if (step_back)
        begin
            phase_next = phase_reg - 1'b1;
            if (rev_reg == '0)
            begin
                pos_next = '0;
            end
            else if (pos_reg == '0)
            begin
                pos_next = rev_reg - 1'b1;
            end
            else
            begin
                pos_next = pos_reg - 1'b1;
            end
        end
        if (finish)
        begin
            pos_next = '0;
        end
        rev_next = load_rev ? quotient : rev_reg;

        res_next.coils         = COIL_TABLE[phase_next];
        res_next.moved         = step_fwd | step_back;
        res_next.position      = pos_next;
        res_next.rev_steps_out = rev_next;
        res_next.busy_res      = (stage_next != ST_IDLE);
        res_next.done_res      = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_IDLE;
            phase_reg   <= '0;
            pos_reg     <= '0;
            rev_reg     <= '0;
            runs_reg    <= '0;
            run_cnt_reg <= '0;
            total_reg   <= '0;
            off_reg     <= '0;
            res_reg     <= '0;
        end
        else if (adv)
        begin
            stage_reg   <= stage_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rev_reg     <= rev_next;
            runs_reg    <= runs_next;
            run_cnt_reg <= run_cnt_next;
            total_reg   <= total_next;
            off_reg     <= off_next;
            res_reg     <= res_next;
        end
    end

    assign res = res_reg;
endmodule

>>> hdl/stepper_halfstep_calibrator.sv
// A step beat waits in the input register and its result beat is registered in the result
// register once that is empty or being taken. Throughput: one step beat per cycle while
// result.ready is high; the tick update is a single pass between the input register and the result register.
// Reset clears the sequencer to idle, position and rev_steps to zero, the
// phase to the first table entry, and offset_steps to 150.
`include "assert_macros.svh"

module stepper_halfstep_calibrator #(
    parameter int unsigned CAL_RUNS = shc_pkg::CAL_RUNS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    shc_cfg_if.sink      cfg,
    shc_step_if.sink     step_in,
    shc_result_if.source result
);
    import shc_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [MODE_W-1:0]   mode_reg;
    logic                edge_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic                adv;
    logic                in_take;
    shc_result_t         res;

    assign adv           = in_valid_reg && (!out_valid_reg || result.ready);
    assign step_in.ready = !in_valid_reg || adv;
    assign in_take       = step_in.valid && step_in.ready;
    assign cfg.ready     = 1'b1;

    assign in_valid_next  = in_take || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            offset_reg    <= OFFSET_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                offset_reg <= cfg.offset_steps;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= step_in.mode;
            edge_reg <= step_in.opto_edge;
        end
    end

    shc_seq #(
        .CAL_RUNS (CAL_RUNS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .mode         (mode_reg),
        .opto_edge    (edge_reg),
        .offset_steps (offset_reg),
        .res          (res)
    );

    assign result.valid         = out_valid_reg;
    assign result.coils         = res.coils;
    assign result.moved         = res.moved;
    assign result.position      = res.position;
    assign result.rev_steps_out = res.rev_steps_out;
    assign result.busy_res      = res.busy_res;
    assign result.done_res      = res.done_res;

    `ASSERT_IMPLIES(a_done_zeroes, clk, rst_n, out_valid_reg && res.done_res, !res.busy_res && (res.position == '0))
    `ASSERT_IMPLIES(a_pos_in_range, clk, rst_n, out_valid_reg, (res.position == '0) || (res.position < res.rev_steps_out))
    `ASSERT_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid_reg)
    `ASSERT_NEXT(a_take_fills_in, clk, rst_n, in_take, in_valid_reg)
endmodule

>>> sim/testbench.sv
module testbench;
    import shc_pkg::*;

    localparam int unsigned CAL_RUNS = CAL_RUNS_DEFAULT;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(5);
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = MODE_W'(7);

    localparam logic [COIL_W-1:0] HALF_STEP_COILS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    localparam int unsigned HOLD_CYCLES = 80;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CAL_SEEK,
        SEQ_CAL_COUNT,
        SEQ_CAL_OFFSET,
        SEQ_HOME_SEEK,
        SEQ_HOME_OFFSET
    } seq_stage_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              opto_edge;
        logic              typed;
        shc_result_t       res;
    } scripted_tick_t;

    localparam shc_result_t UNTYPED = '0;

    localparam scripted_tick_t DIRECTED_TICKS [26] = '{
        '{MODE_IDLE,     1'b1, 1'b1, '{4'h1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_FWD,      1'b0, 1'b1, '{4'h3, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_BACK,     1'b1, 1'b1, '{4'h1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_BACK,     1'b0, 1'b1, '{4'h9, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_SPARE_LO, 1'b1, 1'b1, '{4'h9, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_SPARE_HI, 1'b0, 1'b1, '{4'h9, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0}},
        '{MODE_HOME,     1'b1, 1'b1, '{4'h8, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0}},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_HOME,     1'b0, 1'b0, UNTYPED},
        '{MODE_HOME,     1'b1, 1'b0, UNTYPED},
        '{MODE_HOME,     1'b1, 1'b0, UNTYPED},
        '{MODE_HOME,     1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_HOME,     1'b1, 1'b0, UNTYPED},
        '{MODE_FWD,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b0, 1'b0, UNTYPED},
        '{MODE_CAL,      1'b1, 1'b0, UNTYPED}
    };

    logic clk = 1'b0;
    logic rst_n;

    shc_cfg_if    cfg_bus ();
    shc_step_if   step_bus ();
    shc_result_if result_bus ();

    stepper_halfstep_calibrator #(
        .CAL_RUNS(CAL_RUNS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .step_in(step_bus),
        .result(result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [PHASE_W-1:0]  motor_phase;
    logic [POS_W-1:0]    motor_pos;
    logic [POS_W-1:0]    rev_count;
    seq_stage_t          stage;
    logic [4:0]          runs_seen;
    logic [POS_W-1:0]    run_len;
    logic [TOTAL_W-1:0]  run_total;
    logic [OFFSET_W-1:0] offset_left;
    logic [OFFSET_W-1:0] offset_reg;

    shc_result_t expected_results [$];

    int unsigned failures = 0;
    int unsigned reports = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    function automatic void step_forward();
        motor_phase = motor_phase + 1'b1;
        if (rev_count == 0)
            motor_pos = '0;
        else
            motor_pos = POS_W'((32'(motor_pos) + 1) % 32'(rev_count));
    endfunction

    function automatic void step_backward();
        motor_phase = motor_phase - 1'b1;
        if (rev_count == 0)
            motor_pos = '0;
        else
            motor_pos = POS_W'((32'(motor_pos) % 32'(rev_count) + 32'(rev_count) - 1)
                               % 32'(rev_count));
    endfunction

    function automatic shc_result_t advance_sequencer(logic [MODE_W-1:0] m, logic e);
        logic moved;
        logic done;
        moved = 1'b0;
        done = 1'b0;
        case (stage)
            SEQ_IDLE:
            begin
                if (m == MODE_FWD)
                begin
                    step_forward();
                    moved = 1'b1;
                end
                else if (m == MODE_BACK)
                begin
                    step_backward();
                    moved = 1'b1;
                end
                else if (m == MODE_CAL)
                begin
                    stage = SEQ_CAL_SEEK;
                    runs_seen = '0;
                    run_len = '0;
                    run_total = '0;
                    offset_left = '0;
                    step_forward();
                    moved = 1'b1;
                end
                else if (m == MODE_HOME)
                begin
                    stage = SEQ_HOME_SEEK;
                    offset_left = '0;
                    step_backward();
                    moved = 1'b1;
                end
            end
            SEQ_CAL_SEEK:
            begin
                if (m == MODE_CAL)
                begin
                    if (e)
                    begin
                        stage = SEQ_CAL_COUNT;
                        runs_seen = '0;
                        run_len = '0;
                    end
                    else
                    begin
                        step_forward();
                        moved = 1'b1;
                    end
                end
            end
            SEQ_CAL_COUNT:
            begin
                if (m == MODE_CAL)
                begin
                    if (e)
                    begin
                        run_total = run_total + TOTAL_W'(run_len);
                        runs_seen = runs_seen + 1'b1;
                        run_len = '0;
                        if (runs_seen >= CAL_RUNS)
                        begin
                            stage = SEQ_CAL_OFFSET;
                            offset_left = offset_reg;
                        end
                    end
                    else
                    begin
                        step_forward();
                        moved = 1'b1;
                        if (run_len != 16'hFFFF)
                            run_len = run_len + 1'b1;
                    end
                end
            end
            SEQ_CAL_OFFSET:
            begin
                if (m == MODE_CAL)
                begin
                    if (offset_left != 0)
                    begin
                        step_forward();
                        moved = 1'b1;
                        offset_left = offset_left - 1'b1;
                    end
                    if (offset_left == 0)
                    begin
                        motor_pos = '0;
                        rev_count = POS_W'(run_total / CAL_RUNS);
                        stage = SEQ_IDLE;
                        done = 1'b1;
                    end
                end
            end
            SEQ_HOME_SEEK:
            begin
                if (m == MODE_HOME)
                begin
                    if (e)
                    begin
                        stage = SEQ_HOME_OFFSET;
                        offset_left = offset_reg;
                    end
                    else
                    begin
                        step_backward();
                        moved = 1'b1;
                    end
                end
            end
            SEQ_HOME_OFFSET:
            begin
                if (m == MODE_HOME)
                begin
                    if (offset_left != 0)
                    begin
                        step_backward();
                        moved = 1'b1;
                        offset_left = offset_left - 1'b1;
                    end
                    if (offset_left == 0)
                    begin
                        motor_pos = '0;
                        stage = SEQ_IDLE;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return '{HALF_STEP_COILS[motor_phase], moved, motor_pos, rev_count,
                 stage != SEQ_IDLE, done};
    endfunction

    task automatic offer_tick(input logic [MODE_W-1:0] m, input logic e,
                              input logic typed, input shc_result_t typed_res);
        shc_result_t predicted;
        predicted = advance_sequencer(m, e);
        expected_results.push_back(typed ? typed_res : predicted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            step_bus.valid <= 1'b0;
            @(posedge clk);
        end
        step_bus.valid <= 1'b1;
        step_bus.mode <= m;
        step_bus.opto_edge <= e;
        do
            @(posedge clk);
        while (!step_bus.ready);
    endtask

    task automatic drain_results(input int unsigned bound);
        int unsigned waited;
        waited = 0;
        step_bus.valid <= 1'b0;
        while (expected_results.size() != 0 && waited < bound)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        drain_results(20000);
        cfg_bus.valid <= 1'b1;
        cfg_bus.offset_steps <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        offset_reg = value;
    endtask

    // Mostly well-formed sequences: the matching tick with edges at random
    // spacing, plus a little noise that a running sequence has to ignore.
    task automatic run_random(input int unsigned count);
        logic [MODE_W-1:0] m;
        logic              e;
        int unsigned       n;
        int unsigned       pick;
        n = 0;
        while (n < count || stage != SEQ_IDLE)
        begin
            e = 1'($urandom_range(1));
            if (stage == SEQ_IDLE)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    m = MODE_CAL;
                else if (pick < 50)
                    m = MODE_HOME;
                else if (pick < 70)
                    m = MODE_FWD;
                else if (pick < 90)
                    m = MODE_BACK;
                else if (pick < 94)
                    m = MODE_IDLE;
                else
                    m = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            end
            else if (n < count && $urandom_range(99) < 8)
            begin
                m = MODE_W'($urandom_range(7));
            end
            else
            begin
                if (stage == SEQ_HOME_SEEK || stage == SEQ_HOME_OFFSET)
                    m = MODE_HOME;
                else
                    m = MODE_CAL;
                if (stage == SEQ_CAL_SEEK || stage == SEQ_HOME_SEEK)
                    e = ($urandom_range(9) == 0);
                else if (stage == SEQ_CAL_COUNT)
                    e = ($urandom_range(15) == 0);
            end
            offer_tick(m, e, 1'b0, UNTYPED);
            n++;
        end
    endtask

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        shc_result_t got;
        shc_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got = '{result_bus.coils, result_bus.moved, result_bus.position,
                    result_bus.rev_steps_out, result_bus.busy_res, result_bus.done_res};
            if (expected_results.size() == 0)
            begin
                failures++;
                if (reports < 10)
                    $display("unexpected result beat: coils %h position %0d", got.coils,
                             got.position);
                reports++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.coils !== want.coils || got.moved !== want.moved
                    || got.position !== want.position
                    || got.rev_steps_out !== want.rev_steps_out
                    || got.busy_res !== want.busy_res || got.done_res !== want.done_res)
                begin
                    failures++;
                    if (reports < 10)
                        $display({"result mismatch (expected/actual): coils %h/%h moved %b/%b",
                                  " position %0d/%0d rev_steps %0d/%0d busy %b/%b done %b/%b"},
                                 want.coils, got.coils, want.moved, got.moved,
                                 want.position, got.position,
                                 want.rev_steps_out, got.rev_steps_out,
                                 want.busy_res, got.busy_res, want.done_res, got.done_res);
                    reports++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("[stepper_halfstep_calibrator] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        step_bus.valid = 1'b0;
        step_bus.mode = MODE_IDLE;
        step_bus.opto_edge = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.offset_steps = '0;
        motor_phase = '0;
        motor_pos = '0;
        rev_count = '0;
        stage = SEQ_IDLE;
        runs_seen = '0;
        run_len = '0;
        run_total = '0;
        offset_left = '0;
        offset_reg = OFFSET_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 72;
        write_offset(OFFSET_W'(2));
        for (int i = 0; i < $size(DIRECTED_TICKS); i++)
            offer_tick(DIRECTED_TICKS[i].mode, DIRECTED_TICKS[i].opto_edge,
                       DIRECTED_TICKS[i].typed, DIRECTED_TICKS[i].res);
        write_offset(OFFSET_W'(0));
        run_random(120);

        drain_results(20000);
        send_idle_pct = 72;
        recv_idle_pct = 15;
        write_offset(OFFSET_W'(1023));
        run_random(40);

        drain_results(20000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_offset(OFFSET_RESET);
        run_random(100);

        write_offset(OFFSET_W'(1));
        hold_requests++;
        run_random(60);

        // One calibration whose first count run is much longer than the rest.
        write_offset(OFFSET_W'(3));
        offer_tick(MODE_CAL, 1'b0, 1'b0, UNTYPED);
        offer_tick(MODE_CAL, 1'b1, 1'b0, UNTYPED);
        repeat (40) offer_tick(MODE_CAL, 1'b0, 1'b0, UNTYPED);
        offer_tick(MODE_CAL, 1'b1, 1'b0, UNTYPED);
        repeat (CAL_RUNS - 1)
        begin
            repeat (5) offer_tick(MODE_CAL, 1'b0, 1'b0, UNTYPED);
            offer_tick(MODE_CAL, 1'b1, 1'b0, UNTYPED);
        end
        repeat (3) offer_tick(MODE_CAL, 1'b0, 1'b0, UNTYPED);
        run_random(30);

        drain_results(4000);
        repeat (10) @(posedge clk);
        failures += expected_results.size();
        if (failures == 0)
            $display("[stepper_halfstep_calibrator] OK");
        else
            $display("[stepper_halfstep_calibrator] ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+hdl
hdl/shc_pkg.sv
hdl/shc_if.sv
hdl/shc_recip_div.sv
hdl/shc_seq.sv
hdl/stepper_halfstep_calibrator.sv
sim/testbench.sv
